/* rtl/mft_pkg.sv */
// Shared types and constants of the MAC forwarding table
`default_nettype none
package mft_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned KEY_LSB = 16;

	localparam logic [1:0] REQ_LOOKUP = 2'd0;
	localparam logic [1:0] REQ_ADD    = 2'd1;
	localparam logic [1:0] REQ_DELETE = 2'd2;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [WORD_W-1:0] entry_word;
	} req_t;

	typedef struct packed {
		logic              found;
		logic [WORD_W-1:0] result_word;
		logic              table_full;
	} rsp_t;

	// request word as it walks the row of cells
	typedef struct packed {
		logic [1:0]        op;
		logic [WORD_W-1:0] word;
		logic              hit;
		logic [WORD_W-1:0] prior;
		logic              free;
	} tok_t;

	// end-of-walk broadcast to every cell
	typedef struct packed {
		logic fin;
		logic commit;
	} ctl_t;

endpackage
`default_nettype wire

/* rtl/mft_cell.sv */
// One table slot: stored word, valid flag and the token register to the next slot
`default_nettype none
module mft_cell (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	input  wire mft_pkg::tok_t in_tok,
	input  wire mft_pkg::ctl_t ctl,
	output logic           out_valid,
	output mft_pkg::tok_t  out_tok
);
	import mft_pkg::*;

	logic              valid_q;
	logic              pend_q;
	logic [WORD_W-1:0] word_q;
	logic              match;
	logic              claim;
	tok_t              nxt_tok;

	assign match = valid_q && !in_tok.hit &&
		(word_q[WORD_W-1:KEY_LSB] == in_tok.word[WORD_W-1:KEY_LSB]);
	// first free slot seen by an add takes the word provisionally
	assign claim = !valid_q && !in_tok.free && (in_tok.op == REQ_ADD);

	always_comb begin
		nxt_tok       = in_tok;
		nxt_tok.hit   = in_tok.hit | match;
		nxt_tok.prior = match ? word_q : in_tok.prior;
		nxt_tok.free  = in_tok.free | !valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			pend_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
			if (ctl.fin) begin
				pend_q <= 1'b0;
				if (ctl.commit && pend_q) begin
					valid_q <= 1'b1;
				end
			end
			if (in_valid) begin
				if (match && (in_tok.op == REQ_DELETE)) begin
					valid_q <= 1'b0;
				end else if (claim) begin
					pend_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ((match && (in_tok.op == REQ_ADD)) || claim)) begin
			word_q <= in_tok.word;
		end
		if (in_valid) begin
			out_tok <= nxt_tok;
		end
	end

endmodule
`default_nettype wire

/* rtl/mac_forwarding_table.sv */
// The request word walks the row of CAPACITY slot cells, one cell per cycle, and
// busy stays high until done; a new request is taken only while busy is low.
// A new key is held in the first free slot and made valid when the walk ends,
// unless the key was already found in the table.
// Reset clears all valid flags and the control state; stored words are not cleared.
// Results are shown for one cycle under done and cannot be stalled.
`default_nettype none
module mac_forwarding_table #(
	parameter int unsigned CAPACITY = 256
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            start,
	input  wire mft_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output mft_pkg::rsp_t  rsp
);
	import mft_pkg::*;

	logic busy_q;
	logic head_v_q;
	tok_t head_tok_q;
	logic tok_v [CAPACITY+1];
	tok_t tok   [CAPACITY+1];
	ctl_t ctl;
	logic accept;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			head_v_q <= 1'b0;
		end else begin
			head_v_q <= accept;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			head_tok_q.op    <= req.req_type;
			head_tok_q.word  <= req.entry_word;
			head_tok_q.hit   <= 1'b0;
			head_tok_q.prior <= '0;
			head_tok_q.free  <= 1'b0;
		end
	end

	assign tok_v[0] = head_v_q;
	assign tok[0]   = head_tok_q;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		mft_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (tok_v[i]),
			.in_tok   (tok[i]),
			.ctl      (ctl),
			.out_valid(tok_v[i+1]),
			.out_tok  (tok[i+1])
		);
	end

	assign done       = tok_v[CAPACITY];
	assign ctl.fin    = done;
	assign ctl.commit = done && !tok[CAPACITY].hit;

	assign rsp.found       = tok[CAPACITY].hit;
	assign rsp.result_word = tok[CAPACITY].prior;
	assign rsp.table_full  = (tok[CAPACITY].op == REQ_ADD) && !tok[CAPACITY].hit &&
		!tok[CAPACITY].free;

endmodule
`default_nettype wire
